// ----- rtl/core/drd_pkg.sv -----
// shared types, constants and helpers of the detection row decoder
package drd_pkg;

    // value and counter widths
    localparam int VALUE_W     = 32;
    localparam int FIELD_CNT_W = 8;
    localparam int ROW_W       = 16;
    localparam int CLASS_W     = 8;
    localparam int NF_W        = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int THR_W       = 17;
    localparam int OFFS_W      = 12;
    localparam int CORNER_W    = 17;
    localparam int WIDE_W      = 65;
    localparam int OUT_DATA_W  = 184;

    // row layout
    localparam logic [NF_W-1:0]        MIN_FIELDS      = 9'd6;
    localparam logic [NF_W-1:0]        MAX_FIELDS      = 9'd256;
    localparam logic [FIELD_CNT_W-1:0] FIELD_CX        = 8'd0;
    localparam logic [FIELD_CNT_W-1:0] FIELD_CY        = 8'd1;
    localparam logic [FIELD_CNT_W-1:0] FIELD_W         = 8'd2;
    localparam logic [FIELD_CNT_W-1:0] FIELD_H         = 8'd3;
    localparam logic [FIELD_CNT_W-1:0] FIRST_CLASS_AF  = 8'd4;
    localparam logic [FIELD_CNT_W-1:0] FIRST_CLASS_OBJ = 8'd5;

    // row queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_FREE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELDS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE   = 3'd6;

    // register reset values
    localparam logic                  RST_ANCHOR_FREE = 1'b1;
    localparam logic [NF_W-1:0]       RST_FIELDS      = 9'd84;
    localparam logic [ROW_W-1:0]      RST_ROWS        = 16'd8400;
    localparam logic [THR_W-1:0]      RST_THRESHOLD   = 17'd16384;
    localparam logic [OFFS_W-1:0]     RST_X_OFFSET    = 12'd0;
    localparam logic [OFFS_W-1:0]     RST_Y_OFFSET    = 12'd0;
    localparam logic [VALUE_W-1:0]    RST_INV_SCALE   = 32'd65536;

    // configuration registers
    typedef struct packed {
        logic                anchor_free;
        logic [NF_W-1:0]     fields_per_row;
        logic [ROW_W-1:0]    rows_per_frame;
        logic [THR_W-1:0]    threshold;
        logic [OFFS_W-1:0]   x_offset;
        logic [OFFS_W-1:0]   y_offset;
        logic [VALUE_W-1:0]  inv_scale;
    } t_cfg;

    // one finished row, as handed from the front to the back
    typedef struct packed {
        logic                anchor_free;
        logic [VALUE_W-1:0]  center_x;
        logic [VALUE_W-1:0]  center_y;
        logic [VALUE_W-1:0]  raw_w;
        logic [VALUE_W-1:0]  raw_h;
        logic [VALUE_W-1:0]  objectness;
        logic [VALUE_W-1:0]  best_score;
        logic [CLASS_W-1:0]  best_class;
        logic [ROW_W-1:0]    grid;
    } t_row;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // clamp a wide signed value to the signed value range
    function automatic logic [VALUE_W-1:0] sat_value(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic [VALUE_W-1:0]       res;
        hi = WIDE_W'((65'sd1 <<< (VALUE_W - 1)) - 65'sd1);
        lo = -hi - 65'sd1;
        if (v > hi) begin
            res = hi[VALUE_W-1:0];
        end else if (v < lo) begin
            res = lo[VALUE_W-1:0];
        end else begin
            res = v[VALUE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/detection_row_decode.sv -----
// top level of the detection row decoder: registers, front, queue, back
// takes one tensor value per cycle except while a row-closing value waits on a full queue; each row
// of F values gives at most one box; a row's box word passes through the queue and the
// three back stages (corners, multipliers, saturation and threshold)
// a stalled output holds the back; the front then runs on until the four-row queue is full
// synchronous active-low reset clears counters, queue and pipeline valids, loads default registers
module detection_row_decode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [drd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [drd_pkg::VALUE_W-1:0]    i_s_axis_tdata,  // element_value
    // output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // box_x, box_y, box_width, box_height, score, class_label, grid_index
    output logic [drd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    drd_pkg::t_cfg      r_cfg;
    drd_pkg::t_row      w_push_row;
    drd_pkg::t_row      w_head_row;
    drd_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.anchor_free    <= drd_pkg::RST_ANCHOR_FREE;
            r_cfg.fields_per_row <= drd_pkg::RST_FIELDS;
            r_cfg.rows_per_frame <= drd_pkg::RST_ROWS;
            r_cfg.threshold      <= drd_pkg::RST_THRESHOLD;
            r_cfg.x_offset       <= drd_pkg::RST_X_OFFSET;
            r_cfg.y_offset       <= drd_pkg::RST_Y_OFFSET;
            r_cfg.inv_scale      <= drd_pkg::RST_INV_SCALE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                drd_pkg::CFG_ANCHOR_FREE: r_cfg.anchor_free    <= i_cfg_data[0];
                drd_pkg::CFG_FIELDS:      r_cfg.fields_per_row <= i_cfg_data[drd_pkg::NF_W-1:0];
                drd_pkg::CFG_ROWS:        r_cfg.rows_per_frame <= i_cfg_data[drd_pkg::ROW_W-1:0];
                drd_pkg::CFG_THRESHOLD:   r_cfg.threshold      <= i_cfg_data[drd_pkg::THR_W-1:0];
                drd_pkg::CFG_X_OFFSET:    r_cfg.x_offset       <= i_cfg_data[drd_pkg::OFFS_W-1:0];
                drd_pkg::CFG_Y_OFFSET:    r_cfg.y_offset       <= i_cfg_data[drd_pkg::OFFS_W-1:0];
                drd_pkg::CFG_INV_SCALE:   r_cfg.inv_scale      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // value intake and row tracking
    drd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_axis_tvalid),
        .i_value    (i_s_axis_tdata),
        .o_ready    (o_s_axis_tready),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_row      (w_push_row)
    );

    // finished rows waiting for the back
    drd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_row    (w_push_row),
        .i_pop    (w_pop),
        .o_row    (w_head_row),
        .o_status (w_q_status)
    );

    // score and box arithmetic
    drd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (w_q_status),
        .i_row      (w_head_row),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata)
    );

    // a row is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("row pushed into full queue");

    // the back never takes a row from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("row popped from empty queue");

    // input held off only when a row must close and the queue is full
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> w_q_status.full)
        else $error("input stalled with room in the queue");

endmodule

// ----- rtl/core/drd_front.sv -----
// front end: takes values, tracks box fields and best class, closes rows
module drd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  drd_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic [drd_pkg::VALUE_W-1:0] i_value,
    output logic                        o_ready,
    input  drd_pkg::t_q_status          i_q_status,
    output logic                        o_push,
    output drd_pkg::t_row               o_row
);

    logic [drd_pkg::FIELD_CNT_W-1:0] r_field, n_field;
    logic [drd_pkg::ROW_W-1:0]       r_row, n_row;
    logic [drd_pkg::VALUE_W-1:0]     r_cx, n_cx;
    logic [drd_pkg::VALUE_W-1:0]     r_cy, n_cy;
    logic [drd_pkg::VALUE_W-1:0]     r_w, n_w;
    logic [drd_pkg::VALUE_W-1:0]     r_h, n_h;
    logic [drd_pkg::VALUE_W-1:0]     r_obj, n_obj;
    logic [drd_pkg::VALUE_W-1:0]     r_best, n_best;
    logic [drd_pkg::CLASS_W-1:0]     r_class, n_class;

    logic [drd_pkg::NF_W-1:0]        nf;
    logic [drd_pkg::FIELD_CNT_W-1:0] first;
    logic                            row_end;
    logic                            accept;
    logic [drd_pkg::ROW_W:0]         rows;
    logic [drd_pkg::ROW_W:0]         row_inc;

    // row length and class start under the current mode
    always_comb begin
        nf = i_cfg.fields_per_row;
        if (nf < drd_pkg::MIN_FIELDS) begin
            nf = drd_pkg::MIN_FIELDS;
        end else if (nf > drd_pkg::MAX_FIELDS) begin
            nf = drd_pkg::MAX_FIELDS;
        end
        first   = i_cfg.anchor_free ? drd_pkg::FIRST_CLASS_AF : drd_pkg::FIRST_CLASS_OBJ;
        row_end = ({1'b0, r_field} + 9'd1) >= nf;
    end

    // a value that closes a row needs room in the queue
    assign o_ready = !row_end || !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && row_end;

    // zero rows per frame means a plain 16-bit wrap
    assign rows    = (i_cfg.rows_per_frame == '0) ? {1'b1, {drd_pkg::ROW_W{1'b0}}}
                                                  : {1'b0, i_cfg.rows_per_frame};
    assign row_inc = {1'b0, r_row} + 17'd1;

    // field classification and best-class tracking
    always_comb begin
        n_field = r_field;
        n_row   = r_row;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_obj   = r_obj;
        n_best  = r_best;
        n_class = r_class;
        if (accept) begin
            if (r_field == drd_pkg::FIELD_CX) begin
                n_cx = i_value;
            end else if (r_field == drd_pkg::FIELD_CY) begin
                n_cy = i_value;
            end else if (r_field == drd_pkg::FIELD_W) begin
                n_w = i_value;
            end else if (r_field == drd_pkg::FIELD_H) begin
                n_h = i_value;
            end else if (r_field < first) begin
                n_obj = i_value;
            end else if (r_field == first) begin
                n_best  = i_value;
                n_class = '0;
            end else if ($signed(i_value) > $signed(r_best)) begin
                n_best  = i_value;
                n_class = r_field - first;
            end
            if (row_end) begin
                n_field = '0;
                n_row   = (row_inc >= rows) ? '0 : row_inc[drd_pkg::ROW_W-1:0];
            end else begin
                n_field = r_field + 8'd1;
            end
        end
    end

    // finished row word for the queue
    always_comb begin
        o_row.anchor_free = i_cfg.anchor_free;
        o_row.center_x    = r_cx;
        o_row.center_y    = r_cy;
        o_row.raw_w       = r_w;
        o_row.raw_h       = r_h;
        o_row.objectness  = r_obj;
        o_row.best_score  = n_best;
        o_row.best_class  = n_class;
        o_row.grid        = r_row;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= '0;
            r_row   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_obj   <= '0;
            r_best  <= '0;
            r_class <= '0;
        end else begin
            r_field <= n_field;
            r_row   <= n_row;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_w     <= n_w;
            r_h     <= n_h;
            r_obj   <= n_obj;
            r_best  <= n_best;
            r_class <= n_class;
        end
    end

endmodule

// ----- rtl/core/drd_queue.sv -----
// short queue of finished rows between the front and the back
module drd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  drd_pkg::t_row      i_row,
    input  logic               i_pop,
    output drd_pkg::t_row      o_row,
    output drd_pkg::t_q_status o_status
);

    drd_pkg::t_row                   r_mem [drd_pkg::QUEUE_DEPTH];
    logic [drd_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [drd_pkg::QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [drd_pkg::QUEUE_CNT_W-1:0] r_count, n_count;

    // status and head word
    assign o_status.full  = (r_count == drd_pkg::QUEUE_CNT_W'(drd_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_row          = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_row;
        end
    end

endmodule

// ----- rtl/core/drd_back.sv -----
// back end: score, threshold test and box scaling over three stages
module drd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  drd_pkg::t_cfg                  i_cfg,
    input  drd_pkg::t_q_status             i_q_status,
    input  drd_pkg::t_row                  i_row,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [drd_pkg::OUT_DATA_W-1:0] o_data
);

    // stage one: corners as whole pixels
    logic                                r_s1_valid;
    logic                                r_s1_af;
    logic signed [drd_pkg::CORNER_W-1:0] r_s1_cx, r_s1_cy;
    logic [drd_pkg::VALUE_W-1:0]         r_s1_w, r_s1_h, r_s1_obj, r_s1_best;
    logic [drd_pkg::CLASS_W-1:0]         r_s1_class;
    logic [drd_pkg::ROW_W-1:0]           r_s1_grid;

    // stage two: products
    logic                                r_s2_valid;
    logic                                r_s2_af;
    logic signed [drd_pkg::WIDE_W-1:0]   r_s2_score, r_s2_x, r_s2_y, r_s2_w, r_s2_h;
    logic [drd_pkg::VALUE_W-1:0]         r_s2_best;
    logic [drd_pkg::CLASS_W-1:0]         r_s2_class;
    logic [drd_pkg::ROW_W-1:0]           r_s2_grid;

    // output register
    logic                                r_out_valid;
    logic [drd_pkg::OUT_DATA_W-1:0]      r_out_data, n_out_data;

    logic                                advance;
    logic signed [drd_pkg::CORNER_W-1:0] corner_x, corner_y;
    logic signed [drd_pkg::VALUE_W:0]    inv_s;
    logic signed [drd_pkg::WIDE_W-1:0]   score_full;
    logic [drd_pkg::VALUE_W-1:0]         score_sat;
    logic                                pass;

    // corner in whole pixels: max(0, trunc((2c - size) / 2^17)) - offset
    function automatic logic signed [drd_pkg::CORNER_W-1:0] corner_px(
        input logic [drd_pkg::VALUE_W-1:0] c,
        input logic [drd_pkg::VALUE_W-1:0] size,
        input logic [drd_pkg::OFFS_W-1:0]  offs
    );
        logic signed [drd_pkg::VALUE_W+1:0] d;
        logic [drd_pkg::ROW_W-1:0]          whole;
        d     = $signed({c[drd_pkg::VALUE_W-1], c, 1'b0})
              - $signed({{2{size[drd_pkg::VALUE_W-1]}}, size});
        whole = (d > 0) ? d[drd_pkg::VALUE_W:drd_pkg::VALUE_W-15] : '0;
        return $signed({1'b0, whole}) - $signed({5'b0, offs});
    endfunction

    // sign-extend a value to the wide product width
    function automatic logic signed [drd_pkg::WIDE_W-1:0] WIDE_W_EXT(
        input logic [drd_pkg::VALUE_W-1:0] v
    );
        return {{(drd_pkg::WIDE_W - drd_pkg::VALUE_W){v[drd_pkg::VALUE_W-1]}}, v};
    endfunction

    // whole pipeline moves while the output register is free or being taken
    assign advance = !r_out_valid || i_ready;
    assign o_pop   = advance && !i_q_status.empty;
    assign inv_s   = $signed({1'b0, i_cfg.inv_scale});

    assign corner_x = corner_px(i_row.center_x, i_row.raw_w, i_cfg.x_offset);
    assign corner_y = corner_px(i_row.center_y, i_row.raw_h, i_cfg.y_offset);

    // stage three: score, threshold and saturation
    always_comb begin
        if (r_s2_af) begin
            score_full = WIDE_W_EXT(r_s2_best);
        end else begin
            score_full = r_s2_score >>> 16;
        end
        score_sat = drd_pkg::sat_value(score_full);
        pass      = $signed(score_sat) > $signed({15'b0, i_cfg.threshold});
        n_out_data = {r_s2_grid,
                      r_s2_class,
                      score_sat,
                      drd_pkg::sat_value(r_s2_h >>> 16),
                      drd_pkg::sat_value(r_s2_w >>> 16),
                      drd_pkg::sat_value(r_s2_y),
                      drd_pkg::sat_value(r_s2_x)};
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && pass;
        end
    end

    // stage payloads; products are formed at the full wide width
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_af    <= i_row.anchor_free;
            r_s1_cx    <= corner_x;
            r_s1_cy    <= corner_y;
            r_s1_w     <= i_row.raw_w;
            r_s1_h     <= i_row.raw_h;
            r_s1_obj   <= i_row.objectness;
            r_s1_best  <= i_row.best_score;
            r_s1_class <= i_row.best_class;
            r_s1_grid  <= i_row.grid;

            r_s2_af    <= r_s1_af;
            r_s2_score <= $signed(r_s1_obj) * $signed(r_s1_best);
            r_s2_x     <= r_s1_cx * inv_s;
            r_s2_y     <= r_s1_cy * inv_s;
            r_s2_w     <= $signed(r_s1_w) * inv_s;
            r_s2_h     <= $signed(r_s1_h) * inv_s;
            r_s2_best  <= r_s1_best;
            r_s2_class <= r_s1_class;
            r_s2_grid  <= r_s1_grid;

            if (r_s2_valid && pass) begin
                r_out_data <= n_out_data;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule
